// File: rtl/core/prc_pkg.sv
// prc_pkg: shared sizes, opcode codes and lane result type for the
// per-bit reference counter bank; depends on nothing
`timescale 1ns / 1ps

package prc_pkg;

  // number of resource bits and saturation value of each claim counter
  localparam int unsigned NUM_BITS  = 8;
  localparam int unsigned COUNT_MAX = 255;

  // counter width follows the saturation value
  localparam int unsigned CNT_W = $clog2(COUNT_MAX + 1);

  // fixed widths of the transaction fields
  localparam int unsigned OP_W    = 2;
  localparam int unsigned MASK_W  = 8;
  localparam int unsigned CLAIM_W = 8;

  // lanes that the 8-bit mask can reach
  localparam int unsigned LANES_VIS = (NUM_BITS < MASK_W) ? NUM_BITS : MASK_W;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  // what one lane reports for one transaction
  typedef struct packed {
    logic               asserted;
    logic               deasserted;
    logic               query_sel;
    logic [CLAIM_W-1:0] count;
  } lane_res_t;

endpackage

// File: rtl/core/prc_lane.sv
// prc_lane: one saturating claim counter with its update logic and
// registered per-transaction report; depends on prc_pkg
`timescale 1ns / 1ps

module prc_lane import prc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  op_e       op_i,
  input  logic      sel_i,
  output lane_res_t res_o
);

  localparam logic [CNT_W-1:0] CntMax = CNT_W'(COUNT_MAX);
  localparam logic [CNT_W-1:0] CntOne = CNT_W'(1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  lane_res_t        res_q, res_d;

  // counter update and report for the current operation
  always_comb begin
    cnt_d           = cnt_q;
    res_d           = '0;
    res_d.query_sel = sel_i && (op_i == OP_QUERY);
    res_d.count     = CLAIM_W'(cnt_q);
    unique case (op_i)
      OP_ACQUIRE: begin
        if (sel_i) begin
          res_d.asserted = (cnt_q == '0);
          if (cnt_q != CntMax) begin
            cnt_d = cnt_q + CntOne;
          end
        end
      end
      OP_RELEASE: begin
        if (sel_i && (cnt_q != '0)) begin
          cnt_d            = cnt_q - CntOne;
          res_d.deasserted = (cnt_q == CntOne);
        end
      end
      OP_QUERY: begin
        cnt_d = cnt_q;
      end
      OP_CLEAR: begin
        res_d.deasserted = (cnt_q != '0);
        cnt_d            = '0;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (take_i) begin
      cnt_q <= cnt_d;
    end
  end

  // report register
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/core/prc_merge.sv
// prc_merge: combines lane reports into the result masks and picks the
// count of the lowest selected lane for query; depends on prc_pkg
`timescale 1ns / 1ps

module prc_merge import prc_pkg::*; (
  input  logic                       valid_i,
  input  lane_res_t [NUM_BITS-1:0]   lane_res_i,
  output logic      [MASK_W-1:0]     asserted_mask_o,
  output logic      [MASK_W-1:0]     deasserted_mask_o,
  output logic      [CLAIM_W-1:0]    claim_count_o
);

  // gather masks and priority-select the lowest query lane
  always_comb begin
    asserted_mask_o   = '0;
    deasserted_mask_o = '0;
    claim_count_o     = '0;
    if (valid_i) begin
      for (int b = LANES_VIS - 1; b >= 0; b--) begin
        asserted_mask_o[b]   = lane_res_i[b].asserted;
        deasserted_mask_o[b] = lane_res_i[b].deasserted;
        if (lane_res_i[b].query_sel) begin
          claim_count_o = lane_res_i[b].count;
        end
      end
    end
  end

endmodule

// File: rtl/core/per_bit_reference_counter_bank.sv
// per_bit_reference_counter_bank: one claim counter lane per resource bit
// and a merge stage; a transaction is taken every cycle (busy stays low)
// result strobe done_o comes in the cycle after start is accepted
// throughput: one transaction per cycle, as the lane update never holds one off
// reset: rst_ni asynchronous active low, clears every counter and done_o
// the receiver cannot stall; each result is shown for one cycle only
`timescale 1ns / 1ps

module per_bit_reference_counter_bank import prc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    opcode_i,
  input  logic [MASK_W-1:0]  bit_mask_i,
  output logic               done_o,
  output logic [MASK_W-1:0]  asserted_mask_o,
  output logic [MASK_W-1:0]  deasserted_mask_o,
  output logic [CLAIM_W-1:0] claim_count_o
);

  logic                     take;
  logic                     valid_q;
  op_e                      op;
  lane_res_t [NUM_BITS-1:0] lane_res;

  // lanes take an update whenever start is high, so the bank never holds off a transaction
  assign busy = 1'b0;
  assign take = start && !busy;
  assign op   = op_e'(opcode_i);

  // one lane per resource bit; bits beyond the mask field are never selected
  for (genvar b = 0; b < NUM_BITS; b++) begin : g_lane
    logic sel;
    if (b < MASK_W) begin : g_vis
      assign sel = bit_mask_i[b];
    end else begin : g_hid
      assign sel = 1'b0;
    end
    prc_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .take_i (take),
      .op_i   (op),
      .sel_i  (sel),
      .res_o  (lane_res[b])
    );
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take;
    end
  end

  assign done_o = valid_q;

  prc_merge u_merge (
    .valid_i           (valid_q),
    .lane_res_i        (lane_res),
    .asserted_mask_o   (asserted_mask_o),
    .deasserted_mask_o (deasserted_mask_o),
    .claim_count_o     (claim_count_o)
  );

  // each accepted transaction yields exactly one result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> done_o)
    else $error("accepted transaction produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !take |=> !done_o)
    else $error("result without an accepted transaction");

  // a bit cannot be both newly claimed and released in one transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((asserted_mask_o & deasserted_mask_o) == '0))
    else $error("bit both asserted and deasserted");

  // count field only carries data for query
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (op != OP_QUERY) |=> (claim_count_o == '0))
    else $error("claim count nonzero outside query");

endmodule

// File: tb/tb_per_bit_reference_counter_bank.sv
// tb_per_bit_reference_counter_bank: self-checking testbench for the per-bit
// reference counter bank; depends on prc_pkg and per_bit_reference_counter_bank
// a local predictor computes each result, a checker compares every done_o strobe
`timescale 1ns / 1ps

module tb_per_bit_reference_counter_bank;
  import prc_pkg::*;

  // cycles without any accepted transaction or result before giving up
  localparam int unsigned IDLE_LIMIT = 500;
  // extra cycles after the last result, for margin
  localparam int unsigned DRAIN_CYCLES = 4;

  // one expected result plus the transaction that caused it
  typedef struct packed {
    op_e                op;
    logic [MASK_W-1:0]  mask;
    logic [MASK_W-1:0]  asserted;
    logic [MASK_W-1:0]  deasserted;
    logic [CLAIM_W-1:0] count;
  } claim_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    opcode_i;
  logic [MASK_W-1:0]  bit_mask_i;
  logic               done_o;
  logic [MASK_W-1:0]  asserted_mask_o;
  logic [MASK_W-1:0]  deasserted_mask_o;
  logic [CLAIM_W-1:0] claim_count_o;

  // predictor state and pending results
  logic [CNT_W-1:0] claim_cnt_q [NUM_BITS];
  claim_result_t    pending_q [$];

  // sender pacing
  int unsigned burst_left;

  // run statistics
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_errors;
  int unsigned op_hits [4];
  int unsigned sat_hits;
  int unsigned unclaimed_hits;
  int unsigned idle_cycles;

  per_bit_reference_counter_bank i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .bit_mask_i        (bit_mask_i),
    .done_o            (done_o),
    .asserted_mask_o   (asserted_mask_o),
    .deasserted_mask_o (deasserted_mask_o),
    .claim_count_o     (claim_count_o)
  );

  // 4 ns clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // apply one operation to the local counters and build its result
  // lanes above the mask width can never be selected, so only the lanes below it are walked
  function automatic claim_result_t predict_claims(input op_e op, input logic [MASK_W-1:0] mask);
    claim_result_t r;
    logic          found;
    r      = '0;
    r.op   = op;
    r.mask = mask;
    found  = 1'b0;
    for (int b = 0; b < LANES_VIS; b++) begin
      case (op)
        OP_ACQUIRE: begin
          if (mask[b]) begin
            if (claim_cnt_q[b] == '0) r.asserted[b] = 1'b1;
            if (claim_cnt_q[b] < COUNT_MAX) claim_cnt_q[b] = claim_cnt_q[b] + 1'b1;
            else sat_hits++;
          end
        end
        OP_RELEASE: begin
          if (mask[b]) begin
            if (claim_cnt_q[b] != '0) begin
              claim_cnt_q[b] = claim_cnt_q[b] - 1'b1;
              if (claim_cnt_q[b] == '0) r.deasserted[b] = 1'b1;
            end else begin
              unclaimed_hits++;
            end
          end
        end
        OP_QUERY: begin
          // lowest set mask bit wins
          if (mask[b] && !found) begin
            r.count = CLAIM_W'(claim_cnt_q[b]);
            found   = 1'b1;
          end
        end
        default: begin
          // clear ignores the mask
          if (claim_cnt_q[b] != '0) r.deasserted[b] = 1'b1;
          claim_cnt_q[b] = '0;
        end
      endcase
    end
    return r;
  endfunction

  // drive one transaction, wait for it to be taken, then pace the sender
  task automatic send_op(input op_e op, input logic [MASK_W-1:0] mask);
    int unsigned gap;
    start      <= 1'b1;
    opcode_i   <= op;
    bit_mask_i <= mask;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(predict_claims(op, mask));
    n_sent++;
    op_hits[op]++;
    // bursts of random length, separated by random gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // mask shapes: full random, one-hot, empty or full
  function automatic logic [MASK_W-1:0] pick_mask();
    logic [MASK_W-1:0] m;
    case ($urandom_range(0, 3))
      0: m = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
      1: m = ($urandom_range(0, 1) == 0) ? '0 : '1;
      default: m = MASK_W'($urandom);
    endcase
    return m;
  endfunction

  task automatic report_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v, input claim_result_t e);
    if (act_v !== exp_v) begin
      n_errors++;
      $display("%0t ns: %s mismatch (%s mask %h): expected %h, actual %h",
               $time, name, e.op.name(), e.mask, exp_v, act_v);
    end
  endtask

  // result checker: every strobe is matched with the oldest expectation
  always @(posedge clk_i) begin
    claim_result_t e;
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        n_errors++;
        $display("%0t ns: unexpected result: expected none, actual %h/%h/%h",
                 $time, asserted_mask_o, deasserted_mask_o, claim_count_o);
      end else begin
        e = pending_q.pop_front();
        n_checked++;
        report_field("asserted_mask", e.asserted, asserted_mask_o, e);
        report_field("deasserted_mask", e.deasserted, deasserted_mask_o, e);
        report_field("claim_count", e.count, claim_count_o, e);
      end
    end
  end

  // watchdog on cycles where nothing moves
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || done_o) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // queries after reset, release of bits nobody holds and a clear
  task automatic test_reset_state();
    send_op(OP_QUERY, 8'h00);
    send_op(OP_QUERY, 8'h80);
    send_op(OP_RELEASE, 8'hFF);
    send_op(OP_CLEAR, 8'hFF);
  endtask

  // first claim and last release on all bits, empty masks
  task automatic test_acquire_release();
    send_op(OP_ACQUIRE, 8'hFF);
    send_op(OP_ACQUIRE, 8'h00);
    send_op(OP_ACQUIRE, 8'h81);
    send_op(OP_RELEASE, 8'h01);
    send_op(OP_RELEASE, 8'hFF);
    send_op(OP_RELEASE, 8'hFF);
    send_op(OP_RELEASE, 8'h00);
  endtask

  // lowest set bit selection and empty mask
  task automatic test_query();
    send_op(OP_ACQUIRE, 8'h0C);
    send_op(OP_ACQUIRE, 8'h08);
    send_op(OP_QUERY, 8'h0C);
    send_op(OP_QUERY, 8'h08);
    send_op(OP_QUERY, 8'hF8);
    send_op(OP_QUERY, 8'h01);
    send_op(OP_QUERY, 8'h00);
  endtask

  // clear with held and unheld bits, mask ignored
  task automatic test_clear();
    send_op(OP_CLEAR, 8'h00);
    send_op(OP_ACQUIRE, 8'hFF);
    send_op(OP_CLEAR, 8'hA5);
    send_op(OP_QUERY, 8'hFF);
  endtask

  // drive the edge bits to the ceiling and keep acquiring there
  task automatic test_saturation();
    int unsigned sel;
    int unsigned guard;
    guard = 0;
    while (sat_hits < 60 && guard < 600) begin
      sel = $urandom_range(0, 99);
      if (sel < 90) send_op(OP_ACQUIRE, MASK_W'($urandom) | 8'h81);
      else if (sel < 97) send_op(OP_QUERY, pick_mask());
      else send_op(OP_RELEASE, pick_mask());
      guard++;
    end
    // step down from the ceiling and back up
    repeat (3) send_op(OP_RELEASE, 8'h81);
    repeat (5) send_op(OP_ACQUIRE, 8'h81);
    send_op(OP_QUERY, 8'h80);
  endtask

  // mixed traffic with random masks, clears kept rare
  task automatic test_random_mix();
    int unsigned sel;
    repeat (150) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) send_op(OP_ACQUIRE, pick_mask());
      else if (sel < 75) send_op(OP_RELEASE, pick_mask());
      else if (sel < 95) send_op(OP_QUERY, pick_mask());
      else send_op(OP_CLEAR, pick_mask());
    end
  endtask

  initial begin
    n_sent         = 0;
    n_checked      = 0;
    n_errors       = 0;
    sat_hits       = 0;
    unclaimed_hits = 0;
    burst_left     = 0;
    foreach (op_hits[i]) op_hits[i] = 0;
    foreach (claim_cnt_q[i]) claim_cnt_q[i] = '0;
    rst_ni     = 1'b0;
    start      = 1'b0;
    opcode_i   = OP_ACQUIRE;
    bit_mask_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_acquire_release();
    test_query();
    test_clear();
    test_saturation();
    test_random_mix();

    // drain outstanding results
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run covered %0d transactions (acquire %0d, release %0d, query %0d, clear %0d)",
             n_sent, op_hits[OP_ACQUIRE], op_hits[OP_RELEASE], op_hits[OP_QUERY],
             op_hits[OP_CLEAR]);
    $display("%0d results checked, %0d lane acquires at ceiling, %0d unheld lane releases",
             n_checked, sat_hits, unclaimed_hits);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
